// ===== rtl/shcc_pkg.sv =====
// shcc_pkg: shared types and constants of the strip hit centroid clusterer
// depends on nothing; imported by every module of the block
`default_nettype none

package shcc_pkg;

  // field widths
  localparam int SRV_W     = 3;
  localparam int MOD_W     = 4;
  localparam int CHIP_W    = 5;
  localparam int CH_W      = 7;
  localparam int ADC_W     = 3;
  localparam int BC_W      = 7;
  localparam int FBC_W     = 40;
  localparam int WGT_W     = 8;
  localparam int CENT_W    = 15;
  localparam int WTOT_W    = 15;
  localparam int HITS_W    = 8;
  localparam int WSUM_W    = 22;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = CH_W + WGT_W;

  // divider geometry: dividend is weighted sum shifted by the fraction bits
  localparam int DIVD_W = WSUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(CENT_W);

  // weight registers
  localparam int NUM_WEIGHTS = 8;
  localparam int CFG_IDX_W   = 4;
  localparam logic [WGT_W-1:0] WEIGHT_RESET [NUM_WEIGHTS] =
    '{8'd15, 8'd30, 8'd50, 8'd70, 8'd90, 8'd110, 8'd130, 8'd150};

  // adjacency step between neighboring strips
  localparam int ADJ_STEP = 1;

  // saturation limits of the accumulators
  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  // cluster queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // closed cluster as handed from front to back
  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [MOD_W-1:0]  module_tag;
    logic [CHIP_W-1:0] chip;
    logic [BC_W-1:0]   bunch;
    logic [FBC_W-1:0]  full_bunch;
    logic [WSUM_W-1:0] wsum;
    logic [WTOT_W-1:0] wtot;
    logic [HITS_W-1:0] hits;
    logic              done;
    logic              last;
  } clus_rec_t;

  // up to two closed clusters pushed by one hit, in order
  typedef struct packed {
    logic      push_a;
    clus_rec_t rec_a;
    logic      push_b;
    clus_rec_t rec_b;
  } push_t;

  // finished cluster result
  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [MOD_W-1:0]  module_tag;
    logic [CHIP_W-1:0] chip;
    logic [BC_W-1:0]   bunch;
    logic [FBC_W-1:0]  full_bunch;
    logic [CENT_W-1:0] centroid;
    logic [WTOT_W-1:0] wtot;
    logic [HITS_W-1:0] hits;
    logic              done;
    logic              last;
  } result_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/shcc_front.sv =====
// shcc_front: weight registers, hit intake and cluster accumulation
// depends on shcc_pkg; pushes closed clusters into shcc_queue
`default_nettype none

module shcc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [shcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shcc_pkg::WGT_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [shcc_pkg::SRV_W-1:0]       server_index,
  input  logic [shcc_pkg::MOD_W-1:0]       module_index,
  input  logic [shcc_pkg::CHIP_W-1:0]      chip_index,
  input  logic [shcc_pkg::CH_W-1:0]        channel,
  input  logic [shcc_pkg::ADC_W-1:0]       adc_code,
  input  logic [shcc_pkg::BC_W-1:0]        bunch_count,
  input  logic [shcc_pkg::FBC_W-1:0]       full_bunch_count,
  input  logic                             list_last,
  input  logic [shcc_pkg::QCNT_W-1:0]      q_count,
  output shcc_pkg::push_t                  push
);
  import shcc_pkg::*;

  logic [WGT_W-1:0]  weights [NUM_WEIGHTS];

  logic              group_open;
  logic [CH_W-1:0]   prev_channel;
  logic [WSUM_W-1:0] weighted_sum;
  logic [WTOT_W-1:0] weight_sum;
  logic [HITS_W-1:0] group_hits;
  logic [SRV_W-1:0]  tag_server;
  logic [MOD_W-1:0]  tag_module;
  logic [CHIP_W-1:0] tag_chip;
  logic [BC_W-1:0]   tag_bunch;
  logic [FBC_W-1:0]  tag_full_bunch;

  logic              accept;
  logic              closing;
  logic [WGT_W-1:0]  w;
  logic [PROD_W-1:0] prod;
  logic [WSUM_W-1:0] base_ws;
  logic [WTOT_W-1:0] base_wt;
  logic [HITS_W-1:0] base_hits;
  logic [WSUM_W:0]   ws_ext;
  logic [WTOT_W:0]   wt_ext;
  logic [WSUM_W-1:0] weighted_sum_next;
  logic [WTOT_W-1:0] weight_sum_next;
  logic [HITS_W-1:0] group_hits_next;

  // config port never stalls
  assign cfg_ready = 1'b1;

  // take a hit only when the queue has room for two clusters
  assign in_stall = !(q_count <= QCNT_W'(Q_DEPTH - 2));
  assign accept   = in_valid && !in_stall;

  // weight lookup and adjacency test
  assign w       = weights[adc_code];
  assign closing = group_open &&
                   ({1'b0, channel} != ({1'b0, prev_channel} + (CH_W + 1)'(ADJ_STEP)));
  assign prod    = PROD_W'(channel) * PROD_W'(w);

  // accumulate on a fresh or continued cluster, saturating
  always_comb begin
    base_ws   = closing ? '0 : weighted_sum;
    base_wt   = closing ? '0 : weight_sum;
    base_hits = closing ? '0 : group_hits;
    ws_ext    = {1'b0, base_ws} + (WSUM_W + 1)'(prod);
    wt_ext    = {1'b0, base_wt} + (WTOT_W + 1)'(w);
    weighted_sum_next = ws_ext[WSUM_W] ? '1 : ws_ext[WSUM_W-1:0];
    weight_sum_next   = wt_ext[WTOT_W] ? '1 : wt_ext[WTOT_W-1:0];
    group_hits_next   = (base_hits < HITS_MAX) ? base_hits + HITS_W'(1) : base_hits;
  end

  // closed clusters: the broken one first, then the flushed one
  always_comb begin
    push.push_a           = accept && closing;
    push.rec_a.server     = tag_server;
    push.rec_a.module_tag = tag_module;
    push.rec_a.chip       = tag_chip;
    push.rec_a.bunch      = tag_bunch;
    push.rec_a.full_bunch = tag_full_bunch;
    push.rec_a.wsum       = weighted_sum;
    push.rec_a.wtot       = weight_sum;
    push.rec_a.hits       = group_hits;
    push.rec_a.done       = 1'b0;
    push.rec_a.last       = !list_last;

    push.push_b           = accept && list_last;
    push.rec_b.server     = server_index;
    push.rec_b.module_tag = module_index;
    push.rec_b.chip       = chip_index;
    push.rec_b.bunch      = bunch_count;
    push.rec_b.full_bunch = full_bunch_count;
    push.rec_b.wsum       = weighted_sum_next;
    push.rec_b.wtot       = weight_sum_next;
    push.rec_b.hits       = group_hits_next;
    push.rec_b.done       = 1'b1;
    push.rec_b.last       = 1'b1;
  end

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] <= WEIGHT_RESET[i];
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_WEIGHTS))) begin
      weights[cfg_index[ADC_W-1:0]] <= cfg_data;
    end
  end

  // open cluster state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open     <= 1'b0;
      prev_channel   <= '0;
      weighted_sum   <= '0;
      weight_sum     <= '0;
      group_hits     <= '0;
      tag_server     <= '0;
      tag_module     <= '0;
      tag_chip       <= '0;
      tag_bunch      <= '0;
      tag_full_bunch <= '0;
    end else if (accept) begin
      prev_channel   <= channel;
      tag_server     <= server_index;
      tag_module     <= module_index;
      tag_chip       <= chip_index;
      tag_bunch      <= bunch_count;
      tag_full_bunch <= full_bunch_count;
      if (list_last) begin
        group_open   <= 1'b0;
        weighted_sum <= '0;
        weight_sum   <= '0;
        group_hits   <= '0;
      end else begin
        group_open   <= 1'b1;
        weighted_sum <= weighted_sum_next;
        weight_sum   <= weight_sum_next;
        group_hits   <= group_hits_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shcc_queue.sv =====
// shcc_queue: short queue of closed clusters, two pushes and one pop a cycle
// depends on shcc_pkg; fed by shcc_front, drained by shcc_back
`default_nettype none

module shcc_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  shcc_pkg::push_t             push,
  input  logic                        q_pop,
  output logic                        q_valid,
  output shcc_pkg::clus_rec_t         q_rec,
  output logic [shcc_pkg::QCNT_W-1:0] q_count
);
  import shcc_pkg::*;

  clus_rec_t         entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr_b;
  logic [QCNT_W-1:0] n_push;

  // second push lands after the first when both are present
  assign wr_ptr_b = push.push_a ? wr_ptr + QPTR_W'(1) : wr_ptr;
  assign n_push   = QCNT_W'(push.push_a) + QCNT_W'(push.push_b);

  assign q_valid = (q_count != '0);
  assign q_rec   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.push_a) entries[wr_ptr]   <= push.rec_a;
    if (push.push_b) entries[wr_ptr_b] <= push.rec_b;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(n_push);
      rd_ptr  <= rd_ptr + QPTR_W'(q_pop);
      q_count <= q_count + n_push - QCNT_W'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shcc_back.sv =====
// shcc_back: takes closed clusters from the queue, divides out the centroid
// one quotient bit a cycle and holds the result in the output register
// depends on shcc_pkg
`default_nettype none

module shcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  shcc_pkg::clus_rec_t  q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output shcc_pkg::result_t    res
);
  import shcc_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  clus_rec_t         rec;
  logic [WTOT_W-1:0] rem;
  logic [CENT_W-1:0] low;
  logic [CENT_W-1:0] quo;
  logic [DCNT_W-1:0] cnt;
  logic [DIVD_W-1:0] dividend;
  logic [WTOT_W:0]   trial;
  logic              fits;
  logic              out_free;
  logic              load_out;

  assign dividend = {q_rec.wsum, FRAC_BITS'(0)};
  assign trial    = {rem, low[CENT_W-1]};
  assign fits     = trial >= {1'b0, rec.wtot};
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_HOLD) && out_free;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_DIV;
      ST_DIV:  if (cnt == DCNT_W'(CENT_W - 1)) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // restoring divide; the weighted mean stays below 2^CENT_W, so the top
  // part of the dividend is already below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_pop) begin
      rec <= q_rec;
      rem <= dividend[DIVD_W-1:CENT_W];
      low <= dividend[CENT_W-1:0];
      quo <= '0;
      cnt <= '0;
    end else if (state == ST_DIV) begin
      rem <= fits ? WTOT_W'(trial - {1'b0, rec.wtot}) : trial[WTOT_W-1:0];
      low <= {low[CENT_W-2:0], 1'b0};
      quo <= {quo[CENT_W-2:0], fits};
      cnt <= cnt + DCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.server     <= rec.server;
      res.module_tag <= rec.module_tag;
      res.chip       <= rec.chip;
      res.bunch      <= rec.bunch;
      res.full_bunch <= rec.full_bunch;
      // zero total weight gives a zero centroid
      res.centroid   <= (rec.wtot == '0) ? '0 : quo;
      res.wtot       <= rec.wtot;
      res.hits       <= rec.hits;
      res.done       <= rec.done;
      res.last       <= rec.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/strip_hit_centroid_clusterer.sv =====
// strip hit centroid clusterer: one strip hit per item, weighted centroid per cluster
// a closed cluster goes through the queue, the divider and the output register
// throughput: one hit a cycle while the 4-entry cluster queue has room for two;
//   the bit-serial divider (15 quotient bits) works one cluster at a time
// reset: synchronous, active high; clears queue, open cluster and weights to defaults
// depends on shcc_pkg, shcc_front, shcc_queue, shcc_back
`default_nettype none

module strip_hit_centroid_clusterer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [shcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shcc_pkg::WGT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [shcc_pkg::SRV_W-1:0]     server_index,
  input  logic [shcc_pkg::MOD_W-1:0]     module_index,
  input  logic [shcc_pkg::CHIP_W-1:0]    chip_index,
  input  logic [shcc_pkg::CH_W-1:0]      channel,
  input  logic [shcc_pkg::ADC_W-1:0]     adc_code,
  input  logic [shcc_pkg::BC_W-1:0]      bunch_count,
  input  logic [shcc_pkg::FBC_W-1:0]     full_bunch_count,
  input  logic                           list_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [shcc_pkg::SRV_W-1:0]     cl_server,
  output logic [shcc_pkg::MOD_W-1:0]     cl_module,
  output logic [shcc_pkg::CHIP_W-1:0]    cl_chip,
  output logic [shcc_pkg::BC_W-1:0]      cl_bunch,
  output logic [shcc_pkg::FBC_W-1:0]     cl_full_bunch,
  output logic [shcc_pkg::CENT_W-1:0]    centroid,
  output logic [shcc_pkg::WTOT_W-1:0]    weight_total,
  output logic [shcc_pkg::HITS_W-1:0]    hit_count,
  output logic                           list_done,
  output logic                           run_last
);
  import shcc_pkg::*;

  push_t             push;
  logic              q_pop;
  logic              q_valid;
  clus_rec_t         q_rec;
  logic [QCNT_W-1:0] q_count;
  result_t           res;

  // intake and accumulation
  shcc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .server_index     (server_index),
    .module_index     (module_index),
    .chip_index       (chip_index),
    .channel          (channel),
    .adc_code         (adc_code),
    .bunch_count      (bunch_count),
    .full_bunch_count (full_bunch_count),
    .list_last        (list_last),
    .q_count          (q_count),
    .push             (push)
  );

  // closed cluster queue
  shcc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .q_count (q_count)
  );

  // centroid divide and output register
  shcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // result fields
  assign cl_server     = res.server;
  assign cl_module     = res.module_tag;
  assign cl_chip       = res.chip;
  assign cl_bunch      = res.bunch;
  assign cl_full_bunch = res.full_bunch;
  assign centroid      = res.centroid;
  assign weight_total  = res.wtot;
  assign hit_count     = res.hits;
  assign list_done     = res.done;
  assign run_last      = res.last;

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(Q_DEPTH))
    else $error("cluster queue over capacity");

  // back end only pops a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("pop from empty cluster queue");

  // a flushed cluster is always the last result of its hit
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && list_done) |-> run_last)
    else $error("list_done without run_last");

  // no result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
